>>> hw/rtl/dtp_pkg.sv
// ----------------------------------------------------------------------------
// dtp_pkg
// Shared types and constants for the delimited integer text parser.
// ----------------------------------------------------------------------------
package dtp_pkg;

    localparam logic [7:0]  BYTE_CR    = 8'd13;
    localparam logic [7:0]  BYTE_LF    = 8'd10;
    localparam logic [7:0]  BYTE_SPACE = 8'd32;
    localparam logic [7:0]  BYTE_TAB   = 8'd9;
    localparam logic [7:0]  BYTE_PLUS  = 8'd43;
    localparam logic [7:0]  BYTE_MINUS = 8'd45;
    localparam logic [7:0]  BYTE_ZERO  = 8'd48;
    localparam logic [7:0]  BYTE_NINE  = 8'd57;
    localparam logic [7:0]  SEP_RESET  = 8'd44;

    localparam logic [31:0] LIMIT_MAG  = 32'h8000_0000;
    localparam logic [31:0] MAX_POS    = 32'h7fff_ffff;

    typedef enum logic [1:0] {
        PH_SPACE  = 2'd0,
        PH_SIGN   = 2'd1,
        PH_DIGITS = 2'd2,
        PH_STOP   = 2'd3
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic        negative;
        logic [31:0] magnitude;
        logic        too_big;
        logic        field_has_chars;
        logic        line_has_chars;
        logic        held_return;
    } t_state;

    typedef struct packed {
        logic        emitted;
        logic        has_number;
        logic [31:0] number;
        logic        row_done;
        logic        range_error;
    } t_result;

    localparam t_state STATE_RESET = '{
        phase:           PH_SPACE,
        negative:        1'b0,
        magnitude:       32'd0,
        too_big:         1'b0,
        field_has_chars: 1'b0,
        line_has_chars:  1'b0,
        held_return:     1'b0
    };

    function automatic logic is_space(input logic [7:0] c);
        is_space = (c == BYTE_SPACE) || ((c >= BYTE_TAB) && (c <= BYTE_CR));
    endfunction

endpackage

>>> hw/rtl/dtp_step.sv
// ----------------------------------------------------------------------------
// dtp_step
// Next-state and result logic for one text byte.
// ----------------------------------------------------------------------------
module dtp_step (
    input  logic [7:0]      i_sep,
    input  logic [7:0]      i_byte,
    input  logic            i_last,
    input  dtp_pkg::t_state i_state,
    output dtp_pkg::t_state o_state,
    output dtp_pkg::t_result o_res
);
    import dtp_pkg::*;

    typedef struct packed {
        t_state      st;
        logic        take;
        logic [31:0] num;
        logic        err;
    } t_feed;

    function automatic t_state clear_field(input t_state s);
        t_state t;
        t = s;
        t.phase           = PH_SPACE;
        t.negative        = 1'b0;
        t.magnitude       = 32'd0;
        t.too_big         = 1'b0;
        t.field_has_chars = 1'b0;
        return t;
    endfunction

    // saturated field value, {err, value}
    function automatic logic [32:0] field_value(input t_state s);
        logic [32:0] v;
        if (s.negative) begin
            if (s.too_big) v = {1'b1, LIMIT_MAG};
            else           v = {1'b0, 32'd0 - s.magnitude};
        end else begin
            if (s.too_big || (s.magnitude > MAX_POS)) v = {1'b1, MAX_POS};
            else                                     v = {1'b0, s.magnitude};
        end
        return v;
    endfunction

    function automatic t_feed feed_byte(input t_state s, input logic [7:0] c,
                                        input logic [7:0] sep);
        t_feed       f;
        logic        digit;
        logic [34:0] next_mag;
        logic [32:0] fv;
        f        = '0;
        f.st     = s;
        f.st.line_has_chars = 1'b1;
        digit    = (c >= BYTE_ZERO) && (c <= BYTE_NINE);
        next_mag = ({3'b000, s.magnitude} * 35'd10) + {31'd0, c[3:0]};
        fv       = field_value(s);
        if (c == sep) begin
            f.take = 1'b1;
            f.num  = fv[31:0];
            f.err  = fv[32];
            f.st   = clear_field(f.st);
        end else begin
            f.st.field_has_chars = 1'b1;
            if ((s.phase == PH_SPACE) && is_space(c)) begin
                f.st.phase = s.phase;
            end else if ((s.phase == PH_SPACE) && ((c == BYTE_PLUS) || (c == BYTE_MINUS))) begin
                f.st.negative = (c == BYTE_MINUS);
                f.st.phase    = PH_SIGN;
            end else if (s.phase == PH_STOP) begin
                f.st.phase = PH_STOP;
            end else if (!digit) begin
                f.st.phase = PH_STOP;
            end else begin
                f.st.phase = PH_DIGITS;
                if (!s.too_big) begin
                    if (next_mag > {3'b000, LIMIT_MAG}) f.st.too_big   = 1'b1;
                    else                                f.st.magnitude = next_mag[31:0];
                end
            end
        end
        return f;
    endfunction

    always_comb begin
        t_state      s;
        t_result     r;
        t_feed       f1;
        t_feed       f2;
        logic [32:0] fv;
        logic [32:0] fv2;
        s  = i_state;
        r  = '0;
        f1 = feed_byte(i_state, BYTE_CR, i_sep);
        f2 = '0;
        fv = field_value(i_state);

        if (i_byte == BYTE_LF) begin
            s.held_return = 1'b0;
            if (s.field_has_chars) begin
                r.has_number  = 1'b1;
                r.number      = fv[31:0];
                r.range_error = fv[32];
            end
            s              = clear_field(s);
            r.emitted      = 1'b1;
            r.row_done     = 1'b1;
            s.line_has_chars = 1'b0;
        end else if (i_byte == BYTE_CR) begin
            if (i_state.held_return) begin
                s = f1.st;
                if (f1.take) begin
                    r.emitted     = 1'b1;
                    r.has_number  = 1'b1;
                    r.number      = f1.num;
                    r.range_error = f1.err;
                end
            end
            s.held_return = 1'b1;
        end else begin
            if (i_state.held_return) begin
                s = f1.st;
                s.held_return = 1'b0;
                if (f1.take) begin
                    r.emitted     = 1'b1;
                    r.has_number  = 1'b1;
                    r.number      = f1.num;
                    r.range_error = f1.err;
                end
            end
            f2 = feed_byte(s, i_byte, i_sep);
            s  = f2.st;
            if (f2.take) begin
                r.emitted     = 1'b1;
                r.has_number  = 1'b1;
                r.number      = f2.num;
                r.range_error = f2.err;
            end
        end

        fv2 = field_value(s);
        if (i_last) begin
            s.held_return = 1'b0;
            if (s.line_has_chars) begin
                if (s.field_has_chars) begin
                    r.has_number  = 1'b1;
                    r.number      = fv2[31:0];
                    r.range_error = fv2[32];
                end
                r.emitted  = 1'b1;
                r.row_done = 1'b1;
            end
            s = clear_field(s);
            s.line_has_chars = 1'b0;
        end

        o_state = s;
        o_res   = r;
    end

endmodule

>>> hw/rtl/delimited_integer_text_parser_unit.sv
// ----------------------------------------------------------------------------
// delimited_integer_text_parser_unit
// Splits a byte stream into rows and separator-delimited signed integers.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one text byte per request, tlast marks the last byte of a
//   stream. m_axis returns zero or one result per byte: tdata is the field
//   value, tuser[0] says a value is present, tuser[1] flags saturation, and
//   tlast marks the result that closes a row.
//   The cfg channel sets the field separator; it is always ready and must
//   only be written while no bytes are in flight.
// Timing:
//   One byte per cycle sustained while results are taken. An accepted byte
//   sits in the input register, then the field logic loads the output
//   register from it once that register is free to advance.
// Reset:
//   Clears the parse state and both valid flags; separator returns to ','.
// Stall:
//   While the output register holds an untaken result, the input register
//   keeps its byte and s_axis_tready stays high only if it is empty.
// ----------------------------------------------------------------------------
module delimited_integer_text_parser_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  logic        s_axis_tlast,   // stream_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] number
    output logic [1:0]  m_axis_tuser,   // [0] has_number, [1] range_error
    output logic        m_axis_tlast,   // row_done
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data      // [7:0] field_separator
);
    import dtp_pkg::*;

    logic [7:0]  r_sep_byte;
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    t_state      r_state;
    t_state      n_state;
    t_result     n_res;
    logic        r_out_valid;
    logic [31:0] r_out_number;
    logic        r_out_has;
    logic        r_out_err;
    logic        r_out_row;
    logic        adv;

    assign adv           = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || adv;
    assign o_cfg_ready   = 1'b1;

    dtp_step u_step (
        .i_sep   (r_sep_byte),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .i_state (r_state),
        .o_state (n_state),
        .o_res   (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep_byte <= SEP_RESET;
        end else if (i_cfg_valid) begin
            r_sep_byte <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= STATE_RESET;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_in_valid && n_res.emitted;
            if (r_in_valid) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_in_valid) begin
            r_out_number <= n_res.has_number ? n_res.number : 32'd0;
            r_out_has    <= n_res.has_number;
            r_out_err    <= n_res.has_number && n_res.range_error;
            r_out_row    <= n_res.row_done;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_number;
    assign m_axis_tuser  = {r_out_err, r_out_has};
    assign m_axis_tlast  = r_out_row;

endmodule

>>> hw/rtl/dtp_checker.sv
// ----------------------------------------------------------------------------
// dtp_checker
// Port-level checks for the delimited integer text parser.
// ----------------------------------------------------------------------------
module dtp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);
    import dtp_pkg::*;

    // no result survives a reset cycle
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // a flagged value sits at one of the two limits
    a_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |->
            (m_axis_tuser[0] && ((m_axis_tdata == MAX_POS) || (m_axis_tdata == LIMIT_MAG))))
        else $error("range error without saturated value");

    // a result without a value only closes a row, and carries zero
    a_empty_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |->
            (m_axis_tlast && (m_axis_tdata == 32'd0)))
        else $error("empty result that does not close a row");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
             && $stable(m_axis_tlast)))
        else $error("stalled result changed");

endmodule

bind delimited_integer_text_parser_unit dtp_checker u_dtp_checker (.*);

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for delimited_integer_text_parser_unit: streams text
// bytes, predicts every field value and row close, and checks each result.
// ----------------------------------------------------------------------------
module testbench;
    import dtp_pkg::*;

    localparam int PHASE_ITEMS = 112;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS = 20;

    typedef struct packed {
        logic [7:0] text;
        logic       stream_end;
    } t_text_req;

    typedef struct packed {
        logic        has_number;
        logic [31:0] number;
        logic        row_done;
        logic        range_error;
    } t_field_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;    // [7:0] text_byte
    logic        s_axis_tlast = 1'b0;    // stream_end
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;           // [31:0] number
    logic [1:0]  m_axis_tuser;           // [0] has_number, [1] range_error
    logic        m_axis_tlast;           // row_done
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data = 8'd0;      // [7:0] field_separator

    t_text_req     text_reqs[$];
    t_field_result expected_fields[$];
    logic [7:0]    line_bytes[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int bytes_queued = 0;
    int bytes_taken = 0;
    int results_checked = 0;
    int rows_closed = 0;
    int saturated_seen = 0;
    int sep_settings = 1;
    int mismatches = 0;
    int stall_cycles = 0;

    // parser state mirror
    logic [7:0]    sep_cfg = SEP_RESET;
    t_phase        fld_phase = PH_SPACE;
    logic          fld_neg = 1'b0;
    logic [31:0]   fld_mag = 32'd0;
    logic          fld_big = 1'b0;
    logic          fld_chars = 1'b0;
    logic          line_chars = 1'b0;
    logic          cr_held = 1'b0;
    logic          step_emit;
    t_field_result step_out;

    delimited_integer_text_parser_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic void reset_field();
        fld_phase = PH_SPACE;
        fld_neg = 1'b0;
        fld_mag = 32'd0;
        fld_big = 1'b0;
        fld_chars = 1'b0;
    endfunction

    function automatic void emit_field();
        step_emit = 1'b1;
        step_out.has_number = 1'b1;
        step_out.range_error = 1'b0;
        if (fld_neg) begin
            if (fld_big) begin
                step_out.number = LIMIT_MAG;
                step_out.range_error = 1'b1;
            end else begin
                step_out.number = 32'd0 - fld_mag;
            end
        end else if (fld_big || fld_mag > MAX_POS) begin
            step_out.number = MAX_POS;
            step_out.range_error = 1'b1;
        end else begin
            step_out.number = fld_mag;
        end
        reset_field();
    endfunction

    function automatic void absorb_char(input logic [7:0] c);
        logic [63:0] grown;
        line_chars = 1'b1;
        if (c == sep_cfg) begin
            emit_field();
            return;
        end
        fld_chars = 1'b1;
        if (fld_phase == PH_SPACE) begin
            if (c == BYTE_SPACE || (c >= BYTE_TAB && c <= BYTE_CR)) return;
            if (c == BYTE_PLUS || c == BYTE_MINUS) begin
                fld_neg = (c == BYTE_MINUS);
                fld_phase = PH_SIGN;
                return;
            end
        end
        if (fld_phase == PH_STOP) return;
        if (c < BYTE_ZERO || c > BYTE_NINE) begin
            fld_phase = PH_STOP;
            return;
        end
        fld_phase = PH_DIGITS;
        if (!fld_big) begin
            grown = {32'd0, fld_mag} * 64'd10 + {56'd0, c - BYTE_ZERO};
            if (grown > {32'd0, LIMIT_MAG}) fld_big = 1'b1;
            else fld_mag = grown[31:0];
        end
    endfunction

    function automatic void close_row();
        if (fld_chars) emit_field();
        else reset_field();
        step_emit = 1'b1;
        step_out.row_done = 1'b1;
        line_chars = 1'b0;
    endfunction

    function automatic void parse_text_byte(input logic [7:0] b, input logic last);
        step_emit = 1'b0;
        step_out = '0;
        if (b == BYTE_LF) begin
            cr_held = 1'b0;
            close_row();
        end else if (b == BYTE_CR) begin
            if (cr_held) absorb_char(BYTE_CR);
            cr_held = 1'b1;
        end else begin
            if (cr_held) begin
                cr_held = 1'b0;
                absorb_char(BYTE_CR);
            end
            absorb_char(b);
        end
        if (last) begin
            cr_held = 1'b0;
            if (line_chars) close_row();
            reset_field();
            line_chars = 1'b0;
        end
        if (step_emit) expected_fields.push_back(step_out);
    endfunction

    // byte source
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                parse_text_byte(s_axis_tdata, s_axis_tlast);
                void'(text_reqs.pop_front());
                bytes_taken++;
            end
            if (!(s_axis_tvalid && !s_axis_tready)) begin
                if (text_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= text_reqs[0].text;
                    s_axis_tlast <= text_reqs[0].stream_end;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result sink and checker
    always @(posedge i_clk) begin
        t_field_result got;
        t_field_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            if (m_axis_tvalid && m_axis_tready) begin
                got.has_number = m_axis_tuser[0];
                got.number = m_axis_tdata;
                got.row_done = m_axis_tlast;
                got.range_error = m_axis_tuser[1];
                if (expected_fields.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: unexpected result has=%0b num=%0d row=%0b err=%0b",
                                 $time, got.has_number, $signed(got.number),
                                 got.row_done, got.range_error);
                end else begin
                    want = expected_fields.pop_front();
                    results_checked++;
                    if (want.row_done) rows_closed++;
                    if (want.range_error) saturated_seen++;
                    if (got != want) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("%0t: mismatch expected has=%0b num=%0d row=%0b err=%0b",
                                     $time, want.has_number, $signed(want.number),
                                     want.row_done, want.range_error,
                                     ", got has=%0b num=%0d row=%0b err=%0b",
                                     got.has_number, $signed(got.number),
                                     got.row_done, got.range_error);
                    end
                end
            end
        end
    end

    // watchdog on cycles without any byte, result or config transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: timeout, %0d results still expected", $time, expected_fields.size());
            $display("FAIL");
            $finish;
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic last);
        t_text_req req;
        req.text = b;
        req.stream_end = last;
        text_reqs.push_back(req);
        bytes_queued++;
    endtask

    task automatic push_text(input string s);
        for (int k = 0; k < s.len(); k++) push_byte(s[k], 1'b0);
    endtask

    task automatic gen_field();
        logic [31:0] val;
        string digits;
        int mode;
        int sign_sel;
        if ($urandom_range(99) < 8) return;
        repeat ($urandom_range(0, 2)) begin
            case ($urandom_range(0, 5))
                0, 1: line_bytes.push_back(BYTE_SPACE);
                2: line_bytes.push_back(BYTE_TAB);
                3: line_bytes.push_back(8'd11);
                4: line_bytes.push_back(8'd12);
                default: line_bytes.push_back(BYTE_CR);
            endcase
        end
        sign_sel = $urandom_range(0, 2);
        if (sign_sel == 1) line_bytes.push_back(BYTE_PLUS);
        if (sign_sel == 2) line_bytes.push_back(BYTE_MINUS);
        if (sign_sel != 0 && $urandom_range(99) < 6) line_bytes.push_back(BYTE_SPACE);
        if ($urandom_range(99) < 10) line_bytes.push_back(BYTE_ZERO);
        mode = $urandom_range(99);
        if (mode < 40) val = $urandom_range(0, 999);
        else if (mode < 75) val = $urandom;
        else if (mode < 88) val = 32'd2147483645 + $urandom_range(0, 5);
        else val = $urandom;
        digits = $sformatf("%0d", val);
        for (int k = 0; k < digits.len(); k++) line_bytes.push_back(digits[k]);
        if (mode >= 88) begin
            repeat ($urandom_range(1, 3))
                line_bytes.push_back(8'(BYTE_ZERO + $urandom_range(0, 9)));
        end
        if ($urandom_range(99) < 12) begin
            line_bytes.push_back(8'($urandom_range(33, 126)));
            if ($urandom_range(1)) line_bytes.push_back(8'(BYTE_ZERO + $urandom_range(0, 9)));
        end
    endtask

    task automatic gen_line();
        int roll;
        int fields;
        logic end_here;
        line_bytes.delete();
        end_here = 1'b0;
        roll = $urandom_range(99);
        if (roll < 8) begin
            // raw noise
            repeat ($urandom_range(1, 8)) line_bytes.push_back(8'($urandom_range(0, 255)));
            end_here = ($urandom_range(9) == 0);
        end else if (roll < 13) begin
            line_bytes.push_back(BYTE_LF);
        end else begin
            fields = $urandom_range(1, 5);
            for (int k = 0; k < fields; k++) begin
                if (k != 0) line_bytes.push_back(sep_cfg);
                gen_field();
            end
            if ($urandom_range(99) < 10) line_bytes.push_back(sep_cfg);
            roll = $urandom_range(99);
            if (roll < 65) begin
                line_bytes.push_back(BYTE_LF);
            end else if (roll < 85) begin
                line_bytes.push_back(BYTE_CR);
                line_bytes.push_back(BYTE_LF);
            end else if (roll < 93) begin
                end_here = 1'b1;
            end else begin
                line_bytes.push_back(BYTE_CR);
                end_here = 1'b1;
            end
        end
        if (line_bytes.size() == 0) line_bytes.push_back(BYTE_LF);
        for (int k = 0; k < line_bytes.size(); k++)
            push_byte(line_bytes[k], end_here && (k == line_bytes.size() - 1));
    endtask

    task automatic drain_requests();
        while (text_reqs.size() != 0 || expected_fields.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_separator(input logic [7:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sep_cfg = value;
        sep_settings++;
    endtask

    task automatic run_phase(input logic [7:0] sep, input logic write_sep,
                             input int send_pct, input int recv_pct);
        int target;
        drain_requests();
        if (write_sep) write_separator(sep);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        target = bytes_queued + PHASE_ITEMS;
        while (bytes_queued < target) gen_line();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // min value, positive overflow, CRLF, empty line, byte extremes,
        // held CR released by stream end
        push_text("-2147483648,9999999999");
        push_byte(BYTE_CR, 1'b0);
        push_byte(BYTE_LF, 1'b0);
        push_byte(BYTE_LF, 1'b0);
        push_byte(8'hff, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(SEP_RESET, 1'b0);
        push_byte(BYTE_CR, 1'b1);

        run_phase(SEP_RESET, 1'b0, 0, 0);
        run_phase(8'd59, 1'b1, 45, 0);
        run_phase(8'd0, 1'b1, 0, 45);
        run_phase(8'd255, 1'b1, 20, 20);
        run_phase(BYTE_LF, 1'b1, 0, 0);
        run_phase(BYTE_CR, 1'b1, 45, 0);
        run_phase(BYTE_TAB, 1'b1, 20, 20);
        run_phase(SEP_RESET, 1'b1, 0, 45);
        drain_requests();
        repeat (6) @(posedge i_clk);

        $display("Covered %0d text bytes under %0d separator values with mixed idle and stall.",
                 bytes_taken, sep_settings);
        $display("Checked %0d results: %0d row closes, %0d saturated, %0d mismatches.",
                 results_checked, rows_closed, saturated_seen, mismatches);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
